// ===== hdl/ckfd_pkg.sv =====
`default_nettype none

package ckfd_pkg;

  localparam int unsigned ORIGIN_BYTES = 20;
  localparam int unsigned DEST_BYTES   = 20;
  localparam int unsigned QDEPTH       = 4;
  localparam int unsigned QPTR_W       = $clog2(QDEPTH);

  localparam logic [15:0] LIMIT_RESET = 16'd256;

  // phase of the parser and role of a byte share one encoding
  typedef enum logic [2:0] {
    ROLE_TYPE    = 3'd0,
    ROLE_ORIGIN  = 3'd1,
    ROLE_DEST    = 3'd2,
    ROLE_LEN_HI  = 3'd3,
    ROLE_LEN_LO  = 3'd4,
    ROLE_PAYLOAD = 3'd5,
    ROLE_CK_HI   = 3'd6,
    ROLE_CK_LO   = 3'd7
  } role_t;

  typedef enum logic [1:0] {
    ST_BUSY     = 2'd0,
    ST_OK       = 2'd1,
    ST_BAD_SUM  = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    role_t      role;
    logic       frame_end;
    status_t    status;
  } result_t;

  // classified beat handed from front to back
  typedef struct packed {
    logic [7:0] data;
    role_t      role;
    logic       too_long;
  } entry_t;

  typedef struct packed {
    logic nonempty;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== hdl/ckfd_front.sv =====
`default_nettype none

module ckfd_front import ckfd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data,
  input  wire logic        item_valid,
  input  wire item_t       item,
  input  wire q_stat_t     qstat,
  output logic             push,
  output entry_t           entry
);

  role_t       phase, phase_next;
  logic [15:0] field_count, field_count_next;
  logic [15:0] payload_length, payload_length_next;
  logic [7:0]  len_hi, len_hi_next;
  logic [15:0] payload_limit;

  role_t       cur;
  logic [15:0] count_inc;
  logic [15:0] len_full;
  logic        too_long;

  assign cur       = item.restart ? ROLE_TYPE : phase;
  assign count_inc = field_count + 16'd1;
  assign len_full  = {len_hi, item.rx_byte};
  assign too_long  = (len_full > payload_limit);
  assign push      = item_valid && !qstat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= ROLE_TYPE;
      field_count    <= '0;
      payload_length <= '0;
      len_hi         <= '0;
      payload_limit  <= LIMIT_RESET;
    end else begin
      if (cfg_we) begin
        payload_limit <= cfg_data;
      end
      if (push) begin
        phase          <= phase_next;
        field_count    <= field_count_next;
        payload_length <= payload_length_next;
        len_hi         <= len_hi_next;
      end
    end
  end

  always_comb begin
    phase_next          = cur;
    field_count_next    = field_count;
    payload_length_next = payload_length;
    len_hi_next         = len_hi;
    unique case (cur)
      ROLE_TYPE: begin
        field_count_next = '0;
        phase_next       = ROLE_ORIGIN;
      end
      ROLE_ORIGIN: begin
        if (field_count == 16'(ORIGIN_BYTES - 1)) begin
          field_count_next = '0;
          phase_next       = ROLE_DEST;
        end else begin
          field_count_next = count_inc;
        end
      end
      ROLE_DEST: begin
        if (field_count == 16'(DEST_BYTES - 1)) begin
          field_count_next = '0;
          phase_next       = ROLE_LEN_HI;
        end else begin
          field_count_next = count_inc;
        end
      end
      ROLE_LEN_HI: begin
        len_hi_next = item.rx_byte;
        phase_next  = ROLE_LEN_LO;
      end
      ROLE_LEN_LO: begin
        payload_length_next = len_full;
        field_count_next    = '0;
        if (too_long) begin
          phase_next = ROLE_TYPE;
        end else if (len_full == 16'd0) begin
          phase_next = ROLE_CK_HI;
        end else begin
          phase_next = ROLE_PAYLOAD;
        end
      end
      ROLE_PAYLOAD: begin
        // length is at least one here, so count_inc cannot wrap
        if (count_inc >= payload_length) begin
          field_count_next = '0;
          phase_next       = ROLE_CK_HI;
        end else begin
          field_count_next = count_inc;
        end
      end
      ROLE_CK_HI: begin
        phase_next = ROLE_CK_LO;
      end
      ROLE_CK_LO: begin
        field_count_next = '0;
        phase_next       = ROLE_TYPE;
      end
      default: begin
        phase_next = ROLE_TYPE;
      end
    endcase
  end

  always_comb begin
    entry.data     = item.rx_byte;
    entry.role     = cur;
    entry.too_long = (cur == ROLE_LEN_LO) && too_long;
  end

endmodule

`default_nettype wire

// ===== hdl/ckfd_queue.sv =====
`default_nettype none

module ckfd_queue import ckfd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t wr_entry,
  input  wire logic   pop,
  output entry_t      rd_entry,
  output q_stat_t     qstat
);

  entry_t            slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign rd_entry       = slots[rd_ptr];
  assign qstat.nonempty = (fill != '0);
  assign qstat.full     = (fill == (QPTR_W+1)'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      priority if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ckfd_back.sv =====
`default_nettype none

module ckfd_back import ckfd_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire q_stat_t qstat,
  input  wire entry_t  rd_entry,
  output logic         pop,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  checksum_high, checksum_high_next;
  result_t     result_next;
  logic [15:0] sum_add;

  assign pop     = qstat.nonempty && (!result_valid || !result_stall);
  assign sum_add = running_sum + {8'd0, rd_entry.data};

  always_comb begin
    running_sum_next      = running_sum;
    checksum_high_next    = checksum_high;
    result_next.out_byte  = rd_entry.data;
    result_next.role      = rd_entry.role;
    result_next.frame_end = 1'b0;
    result_next.status    = ST_BUSY;
    unique case (rd_entry.role)
      ROLE_TYPE: begin
        running_sum_next = {8'd0, rd_entry.data};
      end
      ROLE_ORIGIN, ROLE_DEST, ROLE_LEN_HI, ROLE_PAYLOAD: begin
        running_sum_next = sum_add;
      end
      ROLE_LEN_LO: begin
        running_sum_next = sum_add;
        if (rd_entry.too_long) begin
          result_next.frame_end = 1'b1;
          result_next.status    = ST_TOO_LONG;
        end
      end
      ROLE_CK_HI: begin
        checksum_high_next = rd_entry.data;
      end
      ROLE_CK_LO: begin
        result_next.frame_end = 1'b1;
        result_next.status    = ({checksum_high, rd_entry.data} == running_sum) ?
                                ST_OK : ST_BAD_SUM;
      end
      default: begin
        running_sum_next = running_sum;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid  <= 1'b0;
      running_sum   <= '0;
      checksum_high <= '0;
    end else begin
      if (pop) begin
        result_valid  <= 1'b1;
        running_sum   <= running_sum_next;
        checksum_high <= checksum_high_next;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/checksummed_frame_deframer.sv =====
// An accepted byte is written into the queue, then registered on the result port.
// Throughput: one byte per cycle while item_stall is low; the four-beat queue
// between parser and checksum stage fills under result_stall; item_stall flags it full.
// Reset (rst, synchronous): parser expects a type byte, sums and counters clear,
// queue and result register empty, payload_limit returns to 256.
`default_nettype none

module checksummed_frame_deframer import ckfd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire item_t       item,
  output logic             result_valid,
  input  wire logic        result_stall,
  output result_t          result
);

  logic    push;
  logic    pop;
  entry_t  wr_entry;
  entry_t  rd_entry;
  q_stat_t qstat;

  assign item_stall = qstat.full;

  ckfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .qstat      (qstat),
    .push       (push),
    .entry      (wr_entry)
  );

  ckfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (rd_entry),
    .qstat    (qstat)
  );

  ckfd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .qstat        (qstat),
    .rd_entry     (rd_entry),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_end_status : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.frame_end == (result.status != ST_BUSY)))
    else $error("frame_end and status disagree");

  a_ck_lo_ends : assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.role == ROLE_CK_LO) |->
      (result.status == ST_OK || result.status == ST_BAD_SUM))
    else $error("checksum low beat without checksum verdict");

  a_too_long_role : assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == ST_TOO_LONG) |-> (result.role == ROLE_LEN_LO))
    else $error("length abort on a beat other than length low");

  a_no_pop_empty : assert property (@(posedge clk) disable iff (rst)
    pop |-> qstat.nonempty)
    else $error("queue read while empty");

endmodule

`default_nettype wire
